// File: sv/rlu_pkg.sv
`default_nettype none

package rlu_pkg;

  // Field widths of the words on the two channels.
  localparam int FUNC_W   = 1;
  localparam int INDEX_W  = 4;
  localparam int ADDR_W   = 32;
  localparam int PLEN_W   = 6;
  localparam int PORT_W   = 16;
  localparam int LEN_W    = 16;
  localparam int STATUS_W = 2;
  localparam int PROTO_W  = 8;

  localparam int TABLE_ENTRIES = 16;

  localparam logic [PLEN_W-1:0]  PLEN_MAX        = 6'd32;
  localparam logic [LEN_W-1:0]   MAX_PAYLOAD_RST = 16'd1480;
  localparam logic [LEN_W-1:0]   HDR_BYTES       = 16'd20;
  localparam logic [LEN_W:0]     TOTAL_LEN_LIMIT = 17'h0FFFF;
  localparam logic [PROTO_W-1:0] PROTO_TCP       = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP       = 8'd17;
  localparam logic [ADDR_W-1:0]  ADDR_ONES       = 32'hFFFF_FFFF;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 1'b0,
    FUNC_SEND  = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_WRITE    = 2'd0,
    ST_FWD      = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_NO_ROUTE = 2'd3
  } status_t;

  // Word travelling down the cell row, with the running best match.
  typedef struct packed {
    func_t              func;
    logic [INDEX_W-1:0] entry_index;
    logic               entry_enable;
    logic [ADDR_W-1:0]  route_prefix;
    logic [PLEN_W-1:0]  prefix_len;
    logic [PORT_W-1:0]  route_port;
    logic [LEN_W-1:0]   payload_length;
    logic               is_tcp;
    logic [ADDR_W-1:0]  src_addr;
    logic [ADDR_W-1:0]  dst_addr;
    logic               too_long;
    logic               found;
    logic [PLEN_W-1:0]  best_len;
    logic [PORT_W-1:0]  best_port;
  } token_t;

endpackage

`default_nettype wire

// File: sv/rlu_in_if.sv
`default_nettype none

interface rlu_in_if;
  logic                         valid;
  logic                         ready;
  logic [rlu_pkg::FUNC_W-1:0]   func;
  logic [rlu_pkg::INDEX_W-1:0]  entry_index;
  logic                         entry_enable;
  logic [rlu_pkg::ADDR_W-1:0]   route_prefix;
  logic [rlu_pkg::PLEN_W-1:0]   prefix_len;
  logic [rlu_pkg::PORT_W-1:0]   route_port;
  logic [rlu_pkg::LEN_W-1:0]    payload_length;
  logic                         is_tcp;
  logic [rlu_pkg::ADDR_W-1:0]   src_addr;
  logic [rlu_pkg::ADDR_W-1:0]   dst_addr;

  modport source (
    output valid, func, entry_index, entry_enable, route_prefix, prefix_len,
           route_port, payload_length, is_tcp, src_addr, dst_addr,
    input  ready
  );

  modport sink (
    input  valid, func, entry_index, entry_enable, route_prefix, prefix_len,
           route_port, payload_length, is_tcp, src_addr, dst_addr,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/rlu_out_if.sv
`default_nettype none

interface rlu_out_if;
  logic                         valid;
  logic                         ready;
  logic [rlu_pkg::STATUS_W-1:0] status;
  logic [rlu_pkg::PORT_W-1:0]   out_port;
  logic [rlu_pkg::PLEN_W-1:0]   matched_len;
  logic [rlu_pkg::LEN_W-1:0]    total_length;
  logic [rlu_pkg::PROTO_W-1:0]  protocol;
  logic [rlu_pkg::ADDR_W-1:0]   header_src;
  logic [rlu_pkg::ADDR_W-1:0]   header_dst;

  modport source (
    output valid, status, out_port, matched_len, total_length, protocol,
           header_src, header_dst,
    input  ready
  );

  modport sink (
    input  valid, status, out_port, matched_len, total_length, protocol,
           header_src, header_dst,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/rlu_cell.sv
`default_nettype none

module rlu_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            vld_i,
  input  wire rlu_pkg::token_t tok_i,
  output logic                 vld_o,
  output rlu_pkg::token_t      tok_o
);

  logic [rlu_pkg::ADDR_W-1:0] pfx_r;
  logic [rlu_pkg::PLEN_W-1:0] len_r;
  logic [rlu_pkg::PORT_W-1:0] port_r;
  logic                       ent_vld_r;

  logic                       vld_r;
  rlu_pkg::token_t            tok_r;
  rlu_pkg::token_t            tok_nxt;

  logic [rlu_pkg::ADDR_W-1:0] mask;
  logic                       hit;
  logic                       wr_here;

  // A length of 32 shifts the ones out completely, giving the full mask.
  assign mask    = ~(rlu_pkg::ADDR_ONES >> len_r);
  assign hit     = ent_vld_r && (((tok_i.dst_addr ^ pfx_r) & mask) == '0);
  assign wr_here = adv && vld_i && (tok_i.func == rlu_pkg::FUNC_WRITE) &&
                   (32'(tok_i.entry_index) == 32'(CELL_IDX));

  always_comb begin
    tok_nxt = tok_i;
    if ((tok_i.func == rlu_pkg::FUNC_SEND) && hit &&
        (!tok_i.found || (len_r > tok_i.best_len))) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.best_len  = len_r;
      tok_nxt.best_port = port_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      ent_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        vld_r <= vld_i;
      end
      if (wr_here) begin
        ent_vld_r <= tok_i.entry_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
    end
    if (wr_here) begin
      pfx_r  <= tok_i.route_prefix;
      len_r  <= tok_i.prefix_len;
      port_r <= tok_i.route_port;
    end
  end

  assign vld_o = vld_r;
  assign tok_o = tok_r;

endmodule

`default_nettype wire

// File: sv/ipv4_route_lookup_sender.sv
`default_nettype none

// IPv4 route lookup and header builder.
// Words arrive on in_ch (valid/ready). A word with func = write loads one route
// table slot; a word with func = send looks up dst_addr by longest prefix match
// (lowest slot wins ties) and yields the header fields. Every word yields exactly
// one result word on out_ch, in arrival order: write done, forwarded, dropped as
// too long, or dropped for lack of a route.
// The table lives in a row of TABLE_ENTRIES cells, one slot per cell. A word
// moves one cell per cycle while the row advances, so writes and lookups stay
// ordered by construction. A result passes the TABLE_ENTRIES cell registers and
// then the output register; one word is accepted every cycle while out_ch is not
// stalled, limited only by the single output register.
// When the receiver stalls with a result waiting, the whole cell row freezes
// and in_ch.ready drops in the same cycle; nothing is lost or duplicated.
// Reset (rst_n low, synchronous) invalidates all table slots, empties the row
// and sets max_payload to 1480. cfg_we writes max_payload from cfg_wdata and is
// to be used only while no word is in flight.
module ipv4_route_lookup_sender #(
  parameter int TABLE_ENTRIES = rlu_pkg::TABLE_ENTRIES
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [rlu_pkg::LEN_W-1:0] cfg_wdata,
  rlu_in_if.sink                         in_ch,
  rlu_out_if.source                      out_ch
);

  logic [rlu_pkg::LEN_W-1:0] max_payload_r;

  logic                      adv;
  logic                      out_vld_r;
  rlu_pkg::token_t           tok_in;

  logic                      vld [0:TABLE_ENTRIES];
  rlu_pkg::token_t           tok [0:TABLE_ENTRIES];

  rlu_pkg::token_t           last;
  rlu_pkg::status_t          status_nxt;
  logic [rlu_pkg::PORT_W-1:0]  port_nxt;
  logic [rlu_pkg::PLEN_W-1:0]  mlen_nxt;
  logic [rlu_pkg::LEN_W-1:0]   tlen_nxt;
  logic [rlu_pkg::PROTO_W-1:0] proto_nxt;
  logic [rlu_pkg::ADDR_W-1:0]  src_nxt;
  logic [rlu_pkg::ADDR_W-1:0]  dst_nxt;

  rlu_pkg::status_t            status_r;
  logic [rlu_pkg::PORT_W-1:0]  port_r;
  logic [rlu_pkg::PLEN_W-1:0]  mlen_r;
  logic [rlu_pkg::LEN_W-1:0]   tlen_r;
  logic [rlu_pkg::PROTO_W-1:0] proto_r;
  logic [rlu_pkg::ADDR_W-1:0]  src_r;
  logic [rlu_pkg::ADDR_W-1:0]  dst_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= rlu_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_payload_r <= cfg_wdata;
    end
  end

  // The row moves whenever the output register is free or being emptied.
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Entry of the row: clamp the prefix length, judge the payload length once,
  // and start with no match found.
  always_comb begin
    tok_in.func           = rlu_pkg::func_t'(in_ch.func);
    tok_in.entry_index    = in_ch.entry_index;
    tok_in.entry_enable   = in_ch.entry_enable;
    tok_in.route_prefix   = in_ch.route_prefix;
    tok_in.prefix_len     = (in_ch.prefix_len > rlu_pkg::PLEN_MAX) ?
                            rlu_pkg::PLEN_MAX : in_ch.prefix_len;
    tok_in.route_port     = in_ch.route_port;
    tok_in.payload_length = in_ch.payload_length;
    tok_in.is_tcp         = in_ch.is_tcp;
    tok_in.src_addr       = in_ch.src_addr;
    tok_in.dst_addr       = in_ch.dst_addr;
    tok_in.too_long       = (in_ch.payload_length > max_payload_r) ||
                            (({1'b0, in_ch.payload_length} + {1'b0, rlu_pkg::HDR_BYTES})
                             > rlu_pkg::TOTAL_LEN_LIMIT);
    tok_in.found          = 1'b0;
    tok_in.best_len       = '0;
    tok_in.best_port      = '0;
  end

  assign vld[0] = in_ch.valid;
  assign tok[0] = tok_in;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    rlu_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .vld_i (vld[g]),
      .tok_i (tok[g]),
      .vld_o (vld[g+1]),
      .tok_o (tok[g+1])
    );
  end

  // Result formatting at the end of the row. Anything not forwarded carries
  // zeros in all fields except the status.
  assign last = tok[TABLE_ENTRIES];

  always_comb begin
    status_nxt = rlu_pkg::ST_WRITE;
    port_nxt   = '0;
    mlen_nxt   = '0;
    tlen_nxt   = '0;
    proto_nxt  = '0;
    src_nxt    = '0;
    dst_nxt    = '0;
    priority if (last.func == rlu_pkg::FUNC_WRITE) begin
      status_nxt = rlu_pkg::ST_WRITE;
    end else if (last.too_long) begin
      status_nxt = rlu_pkg::ST_TOO_LONG;
    end else if (!last.found) begin
      status_nxt = rlu_pkg::ST_NO_ROUTE;
    end else begin
      status_nxt = rlu_pkg::ST_FWD;
      port_nxt   = last.best_port;
      mlen_nxt   = last.best_len;
      tlen_nxt   = last.payload_length + rlu_pkg::HDR_BYTES;
      proto_nxt  = last.is_tcp ? rlu_pkg::PROTO_TCP : rlu_pkg::PROTO_UDP;
      src_nxt    = last.src_addr;
      dst_nxt    = last.dst_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld[TABLE_ENTRIES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= status_nxt;
      port_r   <= port_nxt;
      mlen_r   <= mlen_nxt;
      tlen_r   <= tlen_nxt;
      proto_r  <= proto_nxt;
      src_r    <= src_nxt;
      dst_r    <= dst_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = status_r;
  assign out_ch.out_port     = port_r;
  assign out_ch.matched_len  = mlen_r;
  assign out_ch.total_length = tlen_r;
  assign out_ch.protocol     = proto_r;
  assign out_ch.header_src   = src_r;
  assign out_ch.header_dst   = dst_r;

  // A waiting result that is not taken must hold back the input side.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while result stalled");

  // A forwarded packet never reports a prefix longer than an address.
  a_fwd_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == rlu_pkg::ST_FWD)) |->
      (out_ch.matched_len <= rlu_pkg::PLEN_MAX))
    else $error("matched length out of range");

  // A forwarded packet carries a TCP or UDP protocol number.
  a_fwd_proto: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == rlu_pkg::ST_FWD)) |->
      ((out_ch.protocol == rlu_pkg::PROTO_TCP) ||
       (out_ch.protocol == rlu_pkg::PROTO_UDP)))
    else $error("bad protocol on forwarded packet");

  // Results that are not forwards leave port, matched length, total length and destination zero.
  a_nonfwd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != rlu_pkg::ST_FWD)) |->
      ((out_ch.out_port == '0) && (out_ch.matched_len == '0) &&
       (out_ch.total_length == '0) && (out_ch.header_dst == '0)))
    else $error("non-forward result carries data");

endmodule

`default_nettype wire
